/* rtl/tdcc_pkg.sv */
// Shared types, constants and tables for the tick-driven calendar clock.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package tdcc_pkg;

	localparam int TICK_BITS        = 24;
	localparam int TICKS_PER_SECOND = 1024;

	// width of the shared divider and of the accumulator
	localparam int DIV_W  = 32;
	// width of the constant operand of the multiply-accumulate unit
	localparam int MAC_BW = 18;

	localparam int SECS_PER_DAY   = 86400;
	localparam int SECS_PER_HOUR  = 3600;
	localparam int SECS_PER_MIN   = 60;
	localparam int DAYS_PER_ERA   = 146097;
	localparam int EPOCH_SHIFT    = 719468;
	localparam int YEARS_PER_ERA  = 400;
	localparam int DAYS_PER_YEAR  = 365;
	localparam int DAYS_4Y        = 1460;
	localparam int DAYS_100Y      = 36524;
	localparam int DAYS_ERA_M1    = 146096;
	localparam int YEARS_PER_CENT = 100;
	localparam int DAYS_PER_WEEK  = 7;
	localparam int WEEKDAY_SHIFT  = 3;
	localparam int MP_NUM         = 153;
	localparam int MP_DEN         = 5;

	// reciprocals floor(2^DIV_W / d); the estimate they give is low by at most one
	localparam longint RCP_ONE = longint'(1) << DIV_W;

	localparam logic [DIV_W-1:0] RCP_SECS_PER_DAY   = DIV_W'(RCP_ONE / SECS_PER_DAY);
	localparam logic [DIV_W-1:0] RCP_SECS_PER_HOUR  = DIV_W'(RCP_ONE / SECS_PER_HOUR);
	localparam logic [DIV_W-1:0] RCP_SECS_PER_MIN   = DIV_W'(RCP_ONE / SECS_PER_MIN);
	localparam logic [DIV_W-1:0] RCP_DAYS_PER_ERA   = DIV_W'(RCP_ONE / DAYS_PER_ERA);
	localparam logic [DIV_W-1:0] RCP_YEARS_PER_ERA  = DIV_W'(RCP_ONE / YEARS_PER_ERA);
	localparam logic [DIV_W-1:0] RCP_DAYS_PER_YEAR  = DIV_W'(RCP_ONE / DAYS_PER_YEAR);
	localparam logic [DIV_W-1:0] RCP_DAYS_4Y        = DIV_W'(RCP_ONE / DAYS_4Y);
	localparam logic [DIV_W-1:0] RCP_DAYS_100Y      = DIV_W'(RCP_ONE / DAYS_100Y);
	localparam logic [DIV_W-1:0] RCP_DAYS_ERA_M1    = DIV_W'(RCP_ONE / DAYS_ERA_M1);
	localparam logic [DIV_W-1:0] RCP_YEARS_PER_CENT = DIV_W'(RCP_ONE / YEARS_PER_CENT);
	localparam logic [DIV_W-1:0] RCP_DAYS_PER_WEEK  = DIV_W'(RCP_ONE / DAYS_PER_WEEK);
	localparam logic [DIV_W-1:0] RCP_MP_NUM         = DIV_W'(RCP_ONE / MP_NUM);
	localparam logic [DIV_W-1:0] RCP_MP_DEN         = DIV_W'(RCP_ONE / MP_DEN);

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
		logic [DIV_W-1:0] recip;
	} div_req_t;

	typedef struct packed {
		logic              en;
		logic              clear;
		logic [DIV_W-1:0]  a;
		logic [MAC_BW-1:0] b;
	} mac_ctl_t;

	typedef enum logic [2:0] {
		DV_IDLE,
		DV_MUL_RCP,
		DV_MUL_DSR,
		DV_SUB,
		DV_FIX
	} div_phase_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TICK,
		ST_NORM,
		ST_ERA,
		ST_CENT,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_M5,
		ST_M6,
		ST_M7,
		ST_LOAD,
		ST_DAYS,
		ST_HOUR,
		ST_MIN,
		ST_WDAY,
		ST_CERA,
		ST_Y1,
		ST_Y2,
		ST_Y3,
		ST_Y4,
		ST_Y5,
		ST_CM1,
		ST_DOY,
		ST_MP,
		ST_DD,
		ST_DONE
	} state_t;

	// day of a March-based year on which the month starts; mm is 0 for January
	function automatic logic [8:0] month_doy(input logic [3:0] mm);
		logic [8:0] r;
		case (mm)
			4'd0:    r = 9'd306;
			4'd1:    r = 9'd337;
			4'd2:    r = 9'd0;
			4'd3:    r = 9'd31;
			4'd4:    r = 9'd61;
			4'd5:    r = 9'd92;
			4'd6:    r = 9'd122;
			4'd7:    r = 9'd153;
			4'd8:    r = 9'd184;
			4'd9:    r = 9'd214;
			4'd10:   r = 9'd245;
			4'd11:   r = 9'd275;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/tick_driven_calendar_clock.sv */
// Tick-driven calendar clock: top level with the sequencer and state registers.
// Depends on tdcc_pkg, tdcc_div and tdcc_mac.
//
// Each request is a sample of a free-running tick counter (op 0) or a set-time
// command (op 1) carrying a Gregorian date and time, read as UTC, plus a counter
// sample. A sample adds the whole seconds elapsed since the stored reference,
// modulo 2^TICK_BITS, to the epoch seconds and the uptime, and moves the
// reference back by the leftover ticks so that no fraction of a second is lost.
// A set-time command loads the reference with the sample and the epoch seconds
// with the date (out-of-range fields carry over as plain arithmetic would;
// the count wraps modulo 2^32). Every request gives exactly one result: year,
// month, day, ISO weekday, hour, minute, second and uptime. The block takes one
// request at a time; in_ready is high only while it is idle, and it takes the
// next request while the last result still waits on the output register.
// A result goes to the output register once the work is done and that register
// is free or being read, and in_ready returns with that load; the work is a chain
// of 13 or 14 divisions by constants on one shared reciprocal-multiplication
// divider (each in the steps launch, multiply by the reciprocal, multiply back,
// subtract, correct, hand over), plus the multiply-accumulate steps of a set-time
// command.
module tick_driven_calendar_clock #(
	parameter int TICK_BITS        = tdcc_pkg::TICK_BITS,
	parameter int TICKS_PER_SECOND = tdcc_pkg::TICKS_PER_SECOND
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [TICK_BITS-1:0] tick_count,
	input  logic [11:0]          set_year,
	input  logic [3:0]           set_month,
	input  logic [4:0]           set_day,
	input  logic [4:0]           set_hour,
	input  logic [5:0]           set_minute,
	input  logic [5:0]           set_second,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [11:0]          cal_year,
	output logic [3:0]           cal_month,
	output logic [4:0]           cal_day,
	output logic [2:0]           cal_weekday,
	output logic [4:0]           cal_hour,
	output logic [5:0]           cal_minute,
	output logic [5:0]           cal_second,
	output logic [31:0]          uptime_seconds
);

	localparam int W  = tdcc_pkg::DIV_W;
	localparam int BW = tdcc_pkg::MAC_BW;
	localparam logic [W-1:0] TICK_RCP = W'(tdcc_pkg::RCP_ONE / TICKS_PER_SECOND);

	tdcc_pkg::state_t   state_q, state_d;
	tdcc_pkg::div_req_t div_req;
	tdcc_pkg::mac_ctl_t mac_ctl;

	logic         div_done;
	logic [W-1:0] div_quo;
	logic [W-1:0] div_rem;
	logic [W-1:0] mac_acc;
	logic         launch_q;
	logic         div_state;
	logic         in_acc;
	logic         out_load;

	// persistent clock state
	logic [TICK_BITS-1:0] ref_q;
	logic [31:0]          epoch_q;
	logic [31:0]          uptime_q;

	// latched request
	logic                 op_q;
	logic [TICK_BITS-1:0] tick_q;
	logic [11:0]          set_year_q;
	logic [3:0]           set_month_q;
	logic [4:0]           set_day_q;
	logic [4:0]           set_hour_q;
	logic [5:0]           set_minute_q;
	logic [5:0]           set_second_q;

	// working registers
	logic signed [13:0] ys_q;
	logic [3:0]         mm_q;
	logic [4:0]         era_q;
	logic [8:0]         yoe_q;
	logic [2:0]         cent_q;
	logic [15:0]        days_q;
	logic [16:0]        rsec_q;
	logic [4:0]         wk_hour_q;
	logic [5:0]         wk_min_q;
	logic [5:0]         wk_sec_q;
	logic [2:0]         wd_q;
	logic [17:0]        doe_q;
	logic [6:0]         t1_q;
	logic [2:0]         t2_q;
	logic               t3_q;
	logic [8:0]         doy_q;
	logic [3:0]         mp_q;
	logic [4:0]         dd_q;

	// result register
	logic        out_valid_q;
	logic [11:0] out_year_q;
	logic [3:0]  out_month_q;
	logic [4:0]  out_day_q;
	logic [2:0]  out_wd_q;
	logic [4:0]  out_hour_q;
	logic [5:0]  out_min_q;
	logic [5:0]  out_sec_q;
	logic [31:0] out_up_q;

	// combinational helpers
	logic [TICK_BITS-1:0] delta;
	logic signed [13:0]   ys_d;
	logic signed [13:0]   adj_d;
	logic [3:0]           mm_d;
	logic [13:0]          ys_bias;
	logic [W-1:0]         set_base;
	logic [W-1:0]         doy_full;
	logic [W-1:0]         y4_num;
	logic [3:0]           m_fin;
	logic [11:0]          y_fin;

	tdcc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	tdcc_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.acc (mac_acc)
	);

	assign in_ready = (state_q == tdcc_pkg::ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == tdcc_pkg::ST_DONE) && (!out_valid_q || out_ready);

	// elapsed ticks wrap with the counter
	assign delta = tick_q - ref_q;

	// normalise month: month 0 is December before, 13..15 run into next year
	always_comb begin
		if (set_month_q == 4'd0) begin
			mm_d  = 4'd11;
			adj_d = -14'sd1;
		end else if (set_month_q > 4'd12) begin
			mm_d  = set_month_q - 4'd13;
			adj_d = 14'sd1;
		end else begin
			mm_d  = set_month_q - 4'd1;
			adj_d = 14'sd0;
		end
		// March-based year: January and February belong to the year before
		ys_d = $signed({2'b00, set_year_q}) + adj_d - ((mm_d < 4'd2) ? 14'sd1 : 14'sd0);
	end

	// bias keeps the era division unsigned; the era is the quotient less one
	assign ys_bias  = ys_q + 14'sd400;
	assign set_base = W'(yoe_q >> 2) - W'(cent_q) + W'(tdcc_pkg::month_doy(mm_q))
		+ W'(set_day_q) - W'(1) - W'(tdcc_pkg::EPOCH_SHIFT);
	assign doy_full = W'(doe_q) - (mac_acc + W'(yoe_q >> 2) - W'(cent_q));
	assign y4_num   = W'(doe_q) - W'(t1_q) + W'(t2_q) - W'(t3_q);
	assign m_fin    = (mp_q < 4'd10) ? mp_q + 4'd3 : mp_q - 4'd9;
	assign y_fin    = 12'(yoe_q) + 12'(era_q[2:0]) * 12'd400
		+ ((m_fin <= 4'd2) ? 12'd1 : 12'd0);

	always_comb begin
		case (state_q)
			tdcc_pkg::ST_TICK, tdcc_pkg::ST_ERA, tdcc_pkg::ST_CENT,
			tdcc_pkg::ST_DAYS, tdcc_pkg::ST_HOUR, tdcc_pkg::ST_MIN,
			tdcc_pkg::ST_WDAY, tdcc_pkg::ST_CERA, tdcc_pkg::ST_Y1,
			tdcc_pkg::ST_Y2, tdcc_pkg::ST_Y3, tdcc_pkg::ST_Y4,
			tdcc_pkg::ST_Y5, tdcc_pkg::ST_MP, tdcc_pkg::ST_DD: div_state = 1'b1;
			default: div_state = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tdcc_pkg::ST_IDLE: begin
				if (in_valid) state_d = op ? tdcc_pkg::ST_NORM : tdcc_pkg::ST_TICK;
			end
			tdcc_pkg::ST_TICK: if (div_done) state_d = tdcc_pkg::ST_DAYS;
			tdcc_pkg::ST_NORM: state_d = tdcc_pkg::ST_ERA;
			tdcc_pkg::ST_ERA:  if (div_done) state_d = tdcc_pkg::ST_CENT;
			tdcc_pkg::ST_CENT: if (div_done) state_d = tdcc_pkg::ST_M1;
			tdcc_pkg::ST_M1:   state_d = tdcc_pkg::ST_M2;
			tdcc_pkg::ST_M2:   state_d = tdcc_pkg::ST_M3;
			tdcc_pkg::ST_M3:   state_d = tdcc_pkg::ST_M4;
			tdcc_pkg::ST_M4:   state_d = tdcc_pkg::ST_M5;
			tdcc_pkg::ST_M5:   state_d = tdcc_pkg::ST_M6;
			tdcc_pkg::ST_M6:   state_d = tdcc_pkg::ST_M7;
			tdcc_pkg::ST_M7:   state_d = tdcc_pkg::ST_LOAD;
			tdcc_pkg::ST_LOAD: state_d = tdcc_pkg::ST_DAYS;
			tdcc_pkg::ST_DAYS: if (div_done) state_d = tdcc_pkg::ST_HOUR;
			tdcc_pkg::ST_HOUR: if (div_done) state_d = tdcc_pkg::ST_MIN;
			tdcc_pkg::ST_MIN:  if (div_done) state_d = tdcc_pkg::ST_WDAY;
			tdcc_pkg::ST_WDAY: if (div_done) state_d = tdcc_pkg::ST_CERA;
			tdcc_pkg::ST_CERA: if (div_done) state_d = tdcc_pkg::ST_Y1;
			tdcc_pkg::ST_Y1:   if (div_done) state_d = tdcc_pkg::ST_Y2;
			tdcc_pkg::ST_Y2:   if (div_done) state_d = tdcc_pkg::ST_Y3;
			tdcc_pkg::ST_Y3:   if (div_done) state_d = tdcc_pkg::ST_Y4;
			tdcc_pkg::ST_Y4:   if (div_done) state_d = tdcc_pkg::ST_Y5;
			tdcc_pkg::ST_Y5:   if (div_done) state_d = tdcc_pkg::ST_CM1;
			tdcc_pkg::ST_CM1:  state_d = tdcc_pkg::ST_DOY;
			tdcc_pkg::ST_DOY:  state_d = tdcc_pkg::ST_MP;
			tdcc_pkg::ST_MP:   if (div_done) state_d = tdcc_pkg::ST_DD;
			tdcc_pkg::ST_DD:   if (div_done) state_d = tdcc_pkg::ST_DONE;
			tdcc_pkg::ST_DONE: if (out_load) state_d = tdcc_pkg::ST_IDLE;
			default:           state_d = tdcc_pkg::ST_IDLE;
		endcase
	end

	// divider and accumulator commands
	always_comb begin
		div_req          = '0;
		mac_ctl          = '0;
		div_req.start    = div_state && !launch_q;
		case (state_q)
			tdcc_pkg::ST_TICK: begin
				div_req.dividend = W'(delta);
				div_req.divisor  = W'(TICKS_PER_SECOND);
				div_req.recip    = TICK_RCP;
			end
			tdcc_pkg::ST_ERA: begin
				div_req.dividend = W'(ys_bias);
				div_req.divisor  = W'(tdcc_pkg::YEARS_PER_ERA);
				div_req.recip    = tdcc_pkg::RCP_YEARS_PER_ERA;
			end
			tdcc_pkg::ST_CENT, tdcc_pkg::ST_Y5: begin
				div_req.dividend = W'(yoe_q);
				div_req.divisor  = W'(tdcc_pkg::YEARS_PER_CENT);
				div_req.recip    = tdcc_pkg::RCP_YEARS_PER_CENT;
			end
			tdcc_pkg::ST_M1, tdcc_pkg::ST_CM1: begin
				mac_ctl.en    = 1'b1;
				mac_ctl.clear = 1'b1;
				mac_ctl.a     = W'(yoe_q);
				mac_ctl.b     = BW'(tdcc_pkg::DAYS_PER_YEAR);
			end
			tdcc_pkg::ST_M2: begin
				mac_ctl.en = 1'b1;
				mac_ctl.a  = {{(W-5){era_q[4]}}, era_q};
				mac_ctl.b  = BW'(tdcc_pkg::DAYS_PER_ERA);
			end
			tdcc_pkg::ST_M3: begin
				mac_ctl.en = 1'b1;
				mac_ctl.a  = set_base;
				mac_ctl.b  = BW'(1);
			end
			tdcc_pkg::ST_M4: begin
				mac_ctl.en    = 1'b1;
				mac_ctl.clear = 1'b1;
				mac_ctl.a     = mac_acc;
				mac_ctl.b     = BW'(tdcc_pkg::SECS_PER_DAY);
			end
			tdcc_pkg::ST_M5: begin
				mac_ctl.en = 1'b1;
				mac_ctl.a  = W'(set_hour_q);
				mac_ctl.b  = BW'(tdcc_pkg::SECS_PER_HOUR);
			end
			tdcc_pkg::ST_M6: begin
				mac_ctl.en = 1'b1;
				mac_ctl.a  = W'(set_minute_q);
				mac_ctl.b  = BW'(tdcc_pkg::SECS_PER_MIN);
			end
			tdcc_pkg::ST_M7: begin
				mac_ctl.en = 1'b1;
				mac_ctl.a  = W'(set_second_q);
				mac_ctl.b  = BW'(1);
			end
			tdcc_pkg::ST_DAYS: begin
				div_req.dividend = epoch_q;
				div_req.divisor  = W'(tdcc_pkg::SECS_PER_DAY);
				div_req.recip    = tdcc_pkg::RCP_SECS_PER_DAY;
			end
			tdcc_pkg::ST_HOUR: begin
				div_req.dividend = W'(rsec_q);
				div_req.divisor  = W'(tdcc_pkg::SECS_PER_HOUR);
				div_req.recip    = tdcc_pkg::RCP_SECS_PER_HOUR;
			end
			tdcc_pkg::ST_MIN: begin
				div_req.dividend = W'(rsec_q);
				div_req.divisor  = W'(tdcc_pkg::SECS_PER_MIN);
				div_req.recip    = tdcc_pkg::RCP_SECS_PER_MIN;
			end
			tdcc_pkg::ST_WDAY: begin
				div_req.dividend = W'(days_q) + W'(tdcc_pkg::WEEKDAY_SHIFT);
				div_req.divisor  = W'(tdcc_pkg::DAYS_PER_WEEK);
				div_req.recip    = tdcc_pkg::RCP_DAYS_PER_WEEK;
			end
			tdcc_pkg::ST_CERA: begin
				div_req.dividend = W'(days_q) + W'(tdcc_pkg::EPOCH_SHIFT);
				div_req.divisor  = W'(tdcc_pkg::DAYS_PER_ERA);
				div_req.recip    = tdcc_pkg::RCP_DAYS_PER_ERA;
			end
			tdcc_pkg::ST_Y1: begin
				div_req.dividend = W'(doe_q);
				div_req.divisor  = W'(tdcc_pkg::DAYS_4Y);
				div_req.recip    = tdcc_pkg::RCP_DAYS_4Y;
			end
			tdcc_pkg::ST_Y2: begin
				div_req.dividend = W'(doe_q);
				div_req.divisor  = W'(tdcc_pkg::DAYS_100Y);
				div_req.recip    = tdcc_pkg::RCP_DAYS_100Y;
			end
			tdcc_pkg::ST_Y3: begin
				div_req.dividend = W'(doe_q);
				div_req.divisor  = W'(tdcc_pkg::DAYS_ERA_M1);
				div_req.recip    = tdcc_pkg::RCP_DAYS_ERA_M1;
			end
			tdcc_pkg::ST_Y4: begin
				div_req.dividend = y4_num;
				div_req.divisor  = W'(tdcc_pkg::DAYS_PER_YEAR);
				div_req.recip    = tdcc_pkg::RCP_DAYS_PER_YEAR;
			end
			tdcc_pkg::ST_MP: begin
				div_req.dividend = W'({doy_q, 2'b00}) + W'(doy_q) + W'(2);
				div_req.divisor  = W'(tdcc_pkg::MP_NUM);
				div_req.recip    = tdcc_pkg::RCP_MP_NUM;
			end
			tdcc_pkg::ST_DD: begin
				div_req.dividend = W'(mp_q) * W'(tdcc_pkg::MP_NUM) + W'(2);
				div_req.divisor  = W'(tdcc_pkg::MP_DEN);
				div_req.recip    = tdcc_pkg::RCP_MP_DEN;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// control and clock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tdcc_pkg::ST_IDLE;
			launch_q    <= 1'b0;
			ref_q       <= '0;
			epoch_q     <= '0;
			uptime_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (div_req.start) begin
				launch_q <= 1'b1;
			end else if (div_done) begin
				launch_q <= 1'b0;
			end
			// advance by whole seconds and keep the leftover ticks
			if (state_q == tdcc_pkg::ST_TICK && div_done) begin
				ref_q    <= tick_q - TICK_BITS'(div_rem);
				epoch_q  <= epoch_q + div_quo;
				uptime_q <= uptime_q + div_quo;
			end
			if (state_q == tdcc_pkg::ST_NORM) begin
				ref_q <= tick_q;
			end
			if (state_q == tdcc_pkg::ST_LOAD) begin
				epoch_q <= mac_acc;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q         <= op;
			tick_q       <= tick_count;
			set_year_q   <= set_year;
			set_month_q  <= set_month;
			set_day_q    <= set_day;
			set_hour_q   <= set_hour;
			set_minute_q <= set_minute;
			set_second_q <= set_second;
		end
		if (state_q == tdcc_pkg::ST_NORM) begin
			ys_q <= ys_d;
			mm_q <= mm_d;
		end
		if (div_done) begin
			case (state_q)
				tdcc_pkg::ST_ERA: begin
					era_q <= 5'(div_quo) - 5'd1;
					yoe_q <= 9'(div_rem);
				end
				tdcc_pkg::ST_CENT, tdcc_pkg::ST_Y5: cent_q <= 3'(div_quo);
				tdcc_pkg::ST_DAYS: begin
					days_q <= 16'(div_quo);
					rsec_q <= 17'(div_rem);
				end
				tdcc_pkg::ST_HOUR: begin
					wk_hour_q <= 5'(div_quo);
					rsec_q    <= 17'(div_rem);
				end
				tdcc_pkg::ST_MIN: begin
					wk_min_q <= 6'(div_quo);
					wk_sec_q <= 6'(div_rem);
				end
				tdcc_pkg::ST_WDAY: wd_q <= 3'(div_rem) + 3'd1;
				tdcc_pkg::ST_CERA: begin
					era_q <= 5'(div_quo);
					doe_q <= 18'(div_rem);
				end
				tdcc_pkg::ST_Y1: t1_q  <= 7'(div_quo);
				tdcc_pkg::ST_Y2: t2_q  <= 3'(div_quo);
				tdcc_pkg::ST_Y3: t3_q  <= div_quo[0];
				tdcc_pkg::ST_Y4: yoe_q <= 9'(div_quo);
				tdcc_pkg::ST_MP: mp_q  <= 4'(div_quo);
				tdcc_pkg::ST_DD: dd_q  <= 5'(W'(doy_q) - div_quo + W'(1));
				default: begin
				end
			endcase
		end
		if (state_q == tdcc_pkg::ST_DOY) begin
			doy_q <= 9'(doy_full);
		end
		// hold the result until taken
		if (out_load) begin
			out_year_q  <= y_fin;
			out_month_q <= m_fin;
			out_day_q   <= dd_q;
			out_wd_q    <= wd_q;
			out_hour_q  <= wk_hour_q;
			out_min_q   <= wk_min_q;
			out_sec_q   <= wk_sec_q;
			out_up_q    <= op_q ? uptime_q : uptime_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign cal_year       = out_year_q;
	assign cal_month      = out_month_q;
	assign cal_day        = out_day_q;
	assign cal_weekday    = out_wd_q;
	assign cal_hour       = out_hour_q;
	assign cal_minute     = out_min_q;
	assign cal_second     = out_sec_q;
	assign uptime_seconds = out_up_q;

endmodule

/* rtl/tdcc_div.sv */
// Divider by a constant through reciprocal multiplication, shared by every division.
// Depends on tdcc_pkg for the request type, the phase type and the width.
module tdcc_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tdcc_pkg::div_req_t      req,
	output logic                    done,
	output logic [tdcc_pkg::DIV_W-1:0] quo,
	output logic [tdcc_pkg::DIV_W-1:0] rem
);

	localparam int W  = tdcc_pkg::DIV_W;
	localparam int PW = 2 * W;

	tdcc_pkg::div_phase_t phase_q, phase_d;

	logic          done_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  d_q;
	logic [W-1:0]  m_q;
	logic [W-1:0]  q_q;
	logic [W-1:0]  r_q;
	logic [PW-1:0] p_q;
	logic [W-1:0]  mul_a;
	logic [W-1:0]  mul_b;
	logic [PW-1:0] prod;

	// next phase: launch, multiply by reciprocal, multiply back, subtract, correct
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			tdcc_pkg::DV_IDLE:    if (req.start) phase_d = tdcc_pkg::DV_MUL_RCP;
			tdcc_pkg::DV_MUL_RCP: phase_d = tdcc_pkg::DV_MUL_DSR;
			tdcc_pkg::DV_MUL_DSR: phase_d = tdcc_pkg::DV_SUB;
			tdcc_pkg::DV_SUB:     phase_d = tdcc_pkg::DV_FIX;
			tdcc_pkg::DV_FIX:     phase_d = tdcc_pkg::DV_IDLE;
			default:              phase_d = tdcc_pkg::DV_IDLE;
		endcase
	end

	// multiplier operands
	always_comb begin
		case (phase_q)
			tdcc_pkg::DV_MUL_DSR: begin
				mul_a = p_q[PW-1:W];
				mul_b = d_q;
			end
			default: begin
				mul_a = x_q;
				mul_b = m_q;
			end
		endcase
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tdcc_pkg::DV_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == tdcc_pkg::DV_FIX);
		end
	end

	// the estimate is the true quotient or one short; one compare and subtract settles it
	always_ff @(posedge clk) begin
		case (phase_q)
			tdcc_pkg::DV_IDLE: begin
				if (req.start) begin
					x_q <= req.dividend;
					d_q <= req.divisor;
					m_q <= req.recip;
				end
			end
			tdcc_pkg::DV_MUL_RCP: p_q <= prod;
			tdcc_pkg::DV_MUL_DSR: begin
				q_q <= p_q[PW-1:W];
				p_q <= prod;
			end
			tdcc_pkg::DV_SUB: r_q <= x_q - p_q[W-1:0];
			tdcc_pkg::DV_FIX: begin
				if (r_q >= d_q) begin
					q_q <= q_q + W'(1);
					r_q <= r_q - d_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign quo  = q_q;
	assign rem  = r_q;

endmodule

/* rtl/tdcc_mac.sv */
// Multiply-accumulate register used to build day and second counts.
// Depends on tdcc_pkg for the control type and widths.
module tdcc_mac (
	input  logic                       clk,
	input  tdcc_pkg::mac_ctl_t         ctl,
	output logic [tdcc_pkg::DIV_W-1:0] acc
);

	localparam int W  = tdcc_pkg::DIV_W;
	localparam int BW = tdcc_pkg::MAC_BW;

	logic [W-1:0]    acc_q;
	logic [W+BW-1:0] prod;
	logic [W-1:0]    base;

	assign prod = ctl.a * ctl.b;
	assign base = ctl.clear ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= base + prod[W-1:0];
		end
	end

	assign acc = acc_q;

endmodule
